[hdl/reserved_page_slot_allocator_assert.svh]
// Assertion macros for the reserved page slot allocator.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef RESERVED_PAGE_SLOT_ALLOCATOR_ASSERT_SVH
`define RESERVED_PAGE_SLOT_ALLOCATOR_ASSERT_SVH

// Plain property, checked on every rising edge outside reset.
`define RPSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define RPSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/rpsa_pkg.sv]
// Shared types and constants of the reserved page slot allocator.
// No dependencies; imported by the adder unit and the top level.
package rpsa_pkg;

  localparam int POOL_PAGES_DEF = 16;
  localparam int PAGE_SHIFT_DEF = 12;

  // Width of the shared adder; holds a page number for any PAGE_SHIFT of 8 or more.
  localparam int ALU_W = 24;

  localparam int ADDR_W   = 32;
  localparam int BASE_W   = 20;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OUTSIDE   = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADDR,
    S_FSUB,
    S_OUT
  } state_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

endpackage

[hdl/rpsa_alu.sv]
// Shared add/subtract unit of the reserved page slot allocator.
// Depends on rpsa_pkg for the default width.
module rpsa_alu import rpsa_pkg::*; #(
  parameter int W = ALU_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         carry
);

  logic [W-1:0] b_op;
  logic [W:0]   sum;

  // When subtracting, a set carry means no borrow, so a >= b.
  assign b_op  = sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};
  assign res   = sum[W-1:0];
  assign carry = sum[W];

endmodule

[hdl/reserved_page_slot_allocator.sv]
// Top level of the reserved page slot allocator: sequencer, bitmap and result register.
// Depends on rpsa_pkg, rpsa_alu and reserved_page_slot_allocator_assert.svh.
//
//  Channel  Direction  Payload                                    Handshake
//  in_      slave      tdata: free_address; tuser: mode           tvalid/tready
//  out_     master     tdata: page_address, page_slot; tuser: st  tvalid/tready
//  cfg_     write      wdata: pool_base_page                      we, no wait
//
// An allocate scans the bitmap from slot zero for the lowest free page, forms its
// page address in S_ADDR and shows the result in S_OUT (an exhausted pool goes
// from the scan straight to S_OUT); a free forms the page offset in S_FSUB and
// shows its result in S_OUT. The bitmap scan tests one slot per cycle through a
// single index register, and one shared adder forms the page address or offset.
// The block takes one transaction at a time: in_tready is high only while idle,
// and a result held against a low out_tready stalls the next acceptance.
// Reset clears every in-use bit at once and sets the base page to zero.
`include "reserved_page_slot_allocator_assert.svh"

module reserved_page_slot_allocator import rpsa_pkg::*; #(
  parameter int POOL_PAGES = POOL_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [BASE_W-1:0]  cfg_wdata,    // pool_base_page
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ADDR_W-1:0]  in_tdata,     // [31:0] free_address
  input  logic               in_tuser,     // [0] mode
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata,    // [31:0] page_address, [35:32] page_slot, zeros
  output logic [STATUS_W-1:0] out_tuser    // [1:0] status
);

  localparam int IDX_W  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int PNUM_W = ADDR_W - PAGE_SHIFT;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0]     base_r;
  logic [POOL_PAGES-1:0] in_use_r, in_use_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;

  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  status_t               res_status_r, res_status_nxt;

  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub, alu_carry;

  logic [PNUM_W-1:0] pgnum;
  logic [IDX_W-1:0]  free_idx;
  logic              in_range;
  logic              misaligned;
  logic              last_slot;

  assign pgnum      = addr_r[ADDR_W-1:PAGE_SHIFT];
  assign misaligned = addr_r[PAGE_SHIFT-1:0] != '0;
  assign last_slot  = idx_r == IDX_W'(POOL_PAGES - 1);

  // The adder forms base + slot while allocating and page - base while freeing.
  always_comb begin
    if (state_r == S_ADDR) begin
      alu_a   = ALU_W'(base_r);
      alu_b   = ALU_W'(idx_r);
      alu_sub = 1'b0;
    end else begin
      alu_a   = ALU_W'(pgnum);
      alu_b   = ALU_W'(base_r);
      alu_sub = 1'b1;
    end
  end

  rpsa_alu #(
    .W(ALU_W)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .res  (alu_res),
    .carry(alu_carry)
  );

  // No borrow and an offset below the pool size puts the page inside the pool.
  assign in_range = alu_carry && (alu_res < ALU_W'(POOL_PAGES));
  assign free_idx = alu_res[IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    in_use_nxt     = in_use_r;
    idx_nxt        = idx_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    res_addr_nxt   = res_addr_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = mode_t'(in_tuser);
          addr_nxt  = in_tdata;
          idx_nxt   = '0;
          state_nxt = (mode_t'(in_tuser) == MODE_FREE) ? S_FSUB : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!in_use_r[idx_r]) begin
          in_use_nxt[idx_r] = 1'b1;
          state_nxt         = S_ADDR;
        end else if (last_slot) begin
          res_addr_nxt   = '0;
          res_slot_nxt   = '0;
          res_status_nxt = ST_EXHAUSTED;
          state_nxt      = S_OUT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_ADDR: begin
        // The page address wraps at the top of the address space.
        res_addr_nxt   = ADDR_W'({alu_res, {PAGE_SHIFT{1'b0}}});
        res_slot_nxt   = SLOT_W'(idx_r);
        res_status_nxt = ST_OK;
        state_nxt      = S_OUT;
      end
      S_FSUB: begin
        res_addr_nxt = '0;
        res_slot_nxt = '0;
        state_nxt    = S_OUT;
        if (!in_range) begin
          res_status_nxt = ST_OUTSIDE;
        end else begin
          idx_nxt = free_idx;
          if (misaligned || !in_use_r[free_idx]) begin
            res_status_nxt = ST_NOT_ALLOC;
          end else begin
            in_use_nxt[free_idx] = 1'b0;
            res_slot_nxt         = SLOT_W'(free_idx);
            res_status_nxt       = ST_OK;
          end
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_use_r <= '0;
      base_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    mode_r       <= mode_nxt;
    addr_r       <= addr_nxt;
    res_addr_r   <= res_addr_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_OUT;
  assign out_tdata  = {4'b0000, res_slot_r, res_addr_r};
  assign out_tuser  = res_status_r;

  // A new transaction is never taken while a result is on offer.
  `RPSA_ASSERT(a_one_at_a_time, clk, rst_n, !(in_tready && out_tvalid), "accept during result")
  // A successful allocate leaves its slot marked in use.
  `RPSA_ASSERT_IMP(a_alloc_marks, clk, rst_n,
    out_tvalid && mode_r == MODE_ALLOC && res_status_r == ST_OK,
    in_use_r[idx_r], "allocated slot not marked")
  // A successful free leaves its slot clear.
  `RPSA_ASSERT_IMP(a_free_clears, clk, rst_n,
    out_tvalid && mode_r == MODE_FREE && res_status_r == ST_OK,
    !in_use_r[idx_r], "freed slot still marked")
  // Exhaustion is reported only when every slot is taken.
  `RPSA_ASSERT_IMP(a_exhausted_full, clk, rst_n,
    out_tvalid && res_status_r == ST_EXHAUSTED,
    &in_use_r, "exhausted with a free slot")

endmodule
